// ===== rtl/core/tpmp_pkg.sv =====
package tpmp_pkg;

  // Field and result widths
  localparam int unsigned FieldW = 63;
  localparam int unsigned ResW   = 30;
  // Reduction step counter: two folding steps for b, then two for a
  localparam int unsigned CntW   = 2;

  // Prime modulus and the exponent modulus (prime minus one)
  localparam logic [ResW-1:0] PRIME_MOD = 30'd1000000007;
  localparam logic [ResW-1:0] EXP_MOD   = 30'd1000000006;

  // 2^30 mod m, used to fold a 30-bit chunk into the running residue
  localparam logic [ResW-1:0] R30_PRIME = 30'd73741817;
  localparam logic [ResW-1:0] R30_EXP   = 30'd73741818;

  // Barrett reciprocals floor(2^60 / m), both fit in 31 bits
  localparam logic [63:0] TWO_POW_60 = 64'd1 << 60;
  localparam logic [31:0] MU_PRIME   = 32'(TWO_POW_60 / 64'd1000000007);
  localparam logic [31:0] MU_EXP     = 32'(TWO_POW_60 / 64'd1000000006);

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic red_mode;
    logic setup1;
    logic setup2;
    logic use_prime;
    logic mul_start;
    logic mul_square;
    logic take_mul;
    logic take_sq;
    logic take_red;
    logic load_result;
  } tpmp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic mul_done;
    logic a_zero;
    logic out_free;
  } tpmp_status_t;

endpackage

// ===== rtl/core/tpmp_modmul.sv =====
module tpmp_modmul import tpmp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            use_prime_i,
  input  logic [ResW-1:0] x_i,
  input  logic [ResW-1:0] y_i,
  input  logic [ResW-1:0] z_i,
  output logic            done_o,
  output logic [ResW-1:0] res_o
);

  // Phase shift register: product, quotient, q*m, remainder, correction
  logic [4:0]  ph_q;
  logic [59:0] prod_q;
  logic [30:0] quo_q;
  logic [31:0] qm_q;
  logic [31:0] rem_q;

  logic [ResW-1:0] mod_w;
  logic [31:0]     mu_w;
  logic [31:0]     op_a;
  logic [31:0]     op_b;
  logic [63:0]     mult;
  logic [31:0]     m1;
  logic [31:0]     m2;
  logic [31:0]     m3;
  logic [31:0]     res32;

  assign mod_w = use_prime_i ? PRIME_MOD : EXP_MOD;
  assign mu_w  = use_prime_i ? MU_PRIME : MU_EXP;

  // One shared multiplier, operands picked by phase
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (ph_q[0]) begin
      op_a = {2'b00, x_i};
      op_b = {2'b00, y_i};
    end else if (ph_q[1]) begin
      op_a = {1'b0, prod_q[59:29]};
      op_b = mu_w;
    end else if (ph_q[2]) begin
      op_a = {1'b0, quo_q};
      op_b = {2'b00, mod_w};
    end
  end

  assign mult = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
    end else begin
      ph_q <= {ph_q[3:0], start_i};
    end
  end

  // Barrett stages; x*y + z stays below m^2, so under 2^60
  always_ff @(posedge clk_i) begin
    if (ph_q[0]) prod_q <= mult[59:0] + 60'(z_i);
    if (ph_q[1]) quo_q  <= mult[61:31];
    if (ph_q[2]) qm_q   <= mult[31:0];
    if (ph_q[3]) rem_q  <= prod_q[31:0] - qm_q;
  end

  // Remainder is below 3m: at most two subtractions of m
  assign m1 = {2'b00, mod_w};
  assign m2 = {1'b0, mod_w, 1'b0};
  assign m3 = m1 + m2;

  always_comb begin
    if (rem_q >= m2) begin
      res32 = rem_q - m2;
    end else if (rem_q >= m1) begin
      res32 = rem_q - m1;
    end else begin
      res32 = rem_q;
    end
  end

  assign res_o  = res32[ResW-1:0];
  assign done_o = ph_q[4];

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ph_q))
    else $error("modmul phase not one-hot");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (ph_q == '0))
    else $error("modmul started while busy");

  a_barrett_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q[4] |-> (rem_q < m3))
    else $error("Barrett remainder out of range");

endmodule

// ===== rtl/core/tpmp_datapath.sv =====
module tpmp_datapath import tpmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpmp_cmd_t         cmd_i,
  output tpmp_status_t      status_o,
  input  logic [FieldW-1:0] base_value_i,
  input  logic [FieldW-1:0] exponent_base_i,
  input  logic [FieldW-1:0] exponent_power_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [ResW-1:0]   residue_o
);

  // Low 60 bits of a and b still to be folded in, top chunk first
  logic [2*ResW-1:0] a_sh_q;
  logic [2*ResW-1:0] b_sh_q;
  logic [FieldW-1:0] exp_q;
  logic [ResW-1:0]   red_a_q;
  logic [ResW-1:0]   red_b_q;
  logic [ResW-1:0]   acc_q;
  logic [ResW-1:0]   sq_q;
  logic [ResW-1:0]   residue_q;
  logic              b_zero_q;
  logic              c_zero_q;
  logic              sel_sq_q;
  logic              sel_red_q;
  logic              out_valid_q;

  logic [ResW-1:0]   mm_x;
  logic [ResW-1:0]   mm_y;
  logic [ResW-1:0]   mm_z;
  logic [ResW-1:0]   mm_res;
  logic              mm_done;
  logic              a_zero;
  logic [ResW-1:0]   special;

  assign a_zero  = (red_a_q == '0);
  assign special = c_zero_q ? '0 : (b_zero_q ? ResW'(1) : '0);

  // Multiplier operands: folding r*2^30 + chunk, or an exponent step
  always_comb begin
    if (sel_red_q) begin
      mm_x = cmd_i.use_prime ? red_a_q : red_b_q;
      mm_y = cmd_i.use_prime ? R30_PRIME : R30_EXP;
      mm_z = cmd_i.use_prime ? a_sh_q[2*ResW-1:ResW] : b_sh_q[2*ResW-1:ResW];
    end else begin
      mm_x = sel_sq_q ? sq_q : acc_q;
      mm_y = sq_q;
      mm_z = '0;
    end
  end

  // Shared modular multiplier
  tpmp_modmul u_modmul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.mul_start),
    .use_prime_i (cmd_i.use_prime),
    .x_i         (mm_x),
    .y_i         (mm_y),
    .z_i         (mm_z),
    .done_o      (mm_done),
    .res_o       (mm_res)
  );

  // Working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_a_q   <= '0;
      red_b_q   <= '0;
      acc_q     <= '0;
      sq_q      <= '0;
      sel_sq_q  <= 1'b0;
      sel_red_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        red_a_q <= ResW'(base_value_i[FieldW-1:2*ResW]);
        red_b_q <= ResW'(exponent_base_i[FieldW-1:2*ResW]);
      end else if (cmd_i.take_red && cmd_i.use_prime) begin
        red_a_q <= mm_res;
      end else if (cmd_i.take_red) begin
        red_b_q <= mm_res;
      end
      if (cmd_i.setup1) begin
        acc_q <= ResW'(1);
        sq_q  <= red_b_q;
      end else if (cmd_i.setup2) begin
        acc_q <= ResW'(1);
        sq_q  <= red_a_q;
      end else if (cmd_i.take_mul) begin
        acc_q <= mm_res;
      end else if (cmd_i.take_sq) begin
        sq_q <= mm_res;
      end
      if (cmd_i.mul_start) begin
        sel_sq_q  <= cmd_i.mul_square;
        sel_red_q <= cmd_i.red_mode;
      end
    end
  end

  // Input chunks and exponent
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      a_sh_q   <= base_value_i[2*ResW-1:0];
      b_sh_q   <= exponent_base_i[2*ResW-1:0];
      exp_q    <= exponent_power_i;
      b_zero_q <= (exponent_base_i == '0);
      c_zero_q <= (exponent_power_i == '0);
    end else begin
      if (cmd_i.take_red && cmd_i.use_prime) begin
        a_sh_q <= {a_sh_q[ResW-1:0], {ResW{1'b0}}};
      end
      if (cmd_i.take_red && !cmd_i.use_prime) begin
        b_sh_q <= {b_sh_q[ResW-1:0], {ResW{1'b0}}};
      end
      if (cmd_i.setup2) begin
        exp_q <= {{(FieldW-ResW){1'b0}}, acc_q};
      end else if (cmd_i.take_mul) begin
        exp_q[0] <= 1'b0;
      end else if (cmd_i.take_sq) begin
        exp_q <= {1'b0, exp_q[FieldW-1:1]};
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) residue_q <= a_zero ? special : acc_q;
  end

  assign out_valid_o = out_valid_q;
  assign residue_o   = residue_q;

  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_lsb  = exp_q[0];
  assign status_o.mul_done = mm_done;
  assign status_o.a_zero   = a_zero;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  a_red_a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_a_q < PRIME_MOD)
    else $error("base residue not reduced");

  a_red_b_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_b_q < EXP_MOD)
    else $error("exponent base residue not reduced");

  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (residue_q < PRIME_MOD))
    else $error("result residue out of range");

endmodule

// ===== rtl/core/tpmp_ctrl.sv =====
module tpmp_ctrl import tpmp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  tpmp_status_t status_i,
  output tpmp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_RWAIT,
    S_PICK,
    S_STEP,
    S_MUL,
    S_SQR,
    S_FINISH
  } state_e;

  localparam logic [CntW-1:0] LastRed = '1;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            pass2_q;

  // State, reduction step counter and pass flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pass2_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) state_q <= S_RED;
        end
        S_RED: begin
          state_q <= S_RWAIT;
        end
        S_RWAIT: begin
          if (status_i.mul_done) begin
            cnt_q   <= cnt_q + CntW'(1);
            state_q <= (cnt_q == LastRed) ? S_PICK : S_RED;
          end
        end
        S_PICK: begin
          pass2_q <= 1'b0;
          state_q <= status_i.a_zero ? S_FINISH : S_STEP;
        end
        S_STEP: begin
          if (status_i.exp_zero) begin
            if (pass2_q) begin
              state_q <= S_FINISH;
            end else begin
              pass2_q <= 1'b1;
            end
          end else if (status_i.exp_lsb) begin
            state_q <= S_MUL;
          end else begin
            state_q <= S_SQR;
          end
        end
        S_MUL, S_SQR: begin
          if (status_i.mul_done) state_q <= S_STEP;
        end
        S_FINISH: begin
          if (status_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Commands decoded from state and status; b is folded first, then a
  always_comb begin
    cmd_o           = '0;
    cmd_o.use_prime = pass2_q;
    case (state_q)
      S_IDLE:   cmd_o.load_in  = in_valid_i;
      S_RED: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.red_mode  = 1'b1;
        cmd_o.use_prime = cnt_q[CntW-1];
      end
      S_RWAIT: begin
        cmd_o.take_red  = status_i.mul_done;
        cmd_o.use_prime = cnt_q[CntW-1];
      end
      S_PICK:   cmd_o.setup1   = !status_i.a_zero;
      S_STEP: begin
        if (status_i.exp_zero) begin
          cmd_o.setup2 = !pass2_q;
        end else begin
          cmd_o.mul_start  = 1'b1;
          cmd_o.mul_square = !status_i.exp_lsb;
        end
      end
      S_MUL:    cmd_o.take_mul    = status_i.mul_done;
      S_SQR:    cmd_o.take_sq     = status_i.mul_done;
      S_FINISH: cmd_o.load_result = status_i.out_free;
      default:  cmd_o.load_in     = 1'b0;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== rtl/core/tower_power_mod_prime.sv =====
// Four 30-bit folding steps reduce b and a, then each pass does one squaring per exponent
// bit below the top set bit and one multiplication per set bit. When a is a multiple of
// the prime, the exponent passes are skipped and the result follows from b and c alone.
// One item is in work at a time; products use the shared five-phase Barrett multiplier.
// The next item can be taken in the cycle after the result is loaded into a free output register.
// Reset (rst_ni low, asynchronous) returns the controller to idle, empties the output.
module tower_power_mod_prime import tpmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FieldW-1:0] base_value_i,
  input  logic [FieldW-1:0] exponent_base_i,
  input  logic [FieldW-1:0] exponent_power_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ResW-1:0]   residue_o
);

  tpmp_cmd_t    cmd;
  tpmp_status_t status;

  // Sequencer
  tpmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Reduction, exponent passes and output register
  tpmp_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .base_value_i     (base_value_i),
    .exponent_base_i  (exponent_base_i),
    .exponent_power_i (exponent_power_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .residue_o        (residue_o)
  );

endmodule
